>>> design/bdc_pkg.sv
// shared types, constants and codes of the binary to decimal ascii converter
package bdc_pkg;

  // field widths
  localparam int NUM_W      = 64;
  localparam int NUM_DIGITS = 20;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 6;
  localparam int COUNT_W    = 5;
  localparam int LIMIT_W    = 6;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;

  // shift-add-3 conversion, several binary bits per cycle
  localparam int STEP_BITS  = 4;
  localparam int CONV_STEPS = NUM_W / STEP_BITS;
  localparam int STEP_CNT_W = $clog2(CONV_STEPS);

  // character and register constants
  localparam logic [CHAR_W-1:0]  ASCII_ZERO        = CHAR_W'(48);
  localparam logic [LIMIT_W-1:0] DIGIT_LIMIT_RESET = LIMIT_W'(32);

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // one converted number waiting for the back end
  typedef struct packed {
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
    logic [COUNT_W-1:0]                 count;
    logic                               rejected;
  } bdc_entry_t;

  // front end sequencer states
  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_CLASS
  } front_state_e;

endpackage

>>> design/bdc_front.sv
// front end: takes a number, converts it to bcd and classifies it against the limit
module bdc_front import bdc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [NUM_W-1:0]   number_i,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  output logic               q_push_o,
  output bdc_entry_t         q_entry_o,
  input  logic               q_full_i
);

  front_state_e                       state_q, state_d;
  logic [STEP_CNT_W-1:0]              step_q;
  logic [NUM_W-1:0]                   bin_q, bin_d;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_q, bcd_d;
  logic [LIMIT_W-1:0]                 limit_q;
  logic [COUNT_W-1:0]                 ndig;
  logic                               accept;

  // limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= DIGIT_LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // one conversion step: a few bits of shift-add-3
  always_comb begin
    logic [NUM_W-1:0]                   bin_v;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_v;
    bin_v = bin_q;
    bcd_v = bcd_q;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd_v[d] >= DIGIT_W'(5)) begin
          bcd_v[d] = bcd_v[d] + DIGIT_W'(3);
        end
      end
      bcd_v = BCD_W'({bcd_v, bin_v[NUM_W-1]});
      bin_v = {bin_v[NUM_W-2:0], 1'b0};
    end
    bin_d = bin_v;
    bcd_d = bcd_v;
  end

  // digit count: position of the highest nonzero digit, at least one
  always_comb begin
    ndig = COUNT_W'(1);
    for (int d = 1; d < NUM_DIGITS; d++) begin
      if (bcd_q[d] != '0) begin
        ndig = COUNT_W'(d + 1);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (push) state_d = F_CONV;
      end
      F_CONV: begin
        if (step_q == STEP_CNT_W'(CONV_STEPS - 1)) state_d = F_CLASS;
      end
      F_CLASS: begin
        if (!q_full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    full     = (state_q != F_IDLE);
    accept   = (state_q == F_IDLE) && push;
    q_push_o = (state_q == F_CLASS) && !q_full_i;
    q_entry_o.digits   = bcd_q;
    q_entry_o.rejected = ({1'b0, ndig} > limit_q);
    q_entry_o.count    = q_entry_o.rejected ? '0 : ndig;
  end

  // state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q <= '0;
      end else if (state_q == F_CONV) begin
        step_q <= step_q + STEP_CNT_W'(1);
      end
    end
  end

  // conversion datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      bin_q <= number_i;
      bcd_q <= '0;
    end else if (state_q == F_CONV) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
  end

  // conversion always runs to the classify step
  a_conv_to_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_CONV && step_q == STEP_CNT_W'(CONV_STEPS - 1)) |=> state_q == F_CLASS)
    else $error("conversion did not end in classify");

endmodule

>>> design/bdc_queue.sv
// short register queue between front and back end
module bdc_queue import bdc_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  bdc_entry_t entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output bdc_entry_t entry_o,
  output logic       valid_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  bdc_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  // status
  always_comb begin
    full_o  = (cnt_q == CntW'(Depth));
    valid_o = (cnt_q != '0);
    entry_o = mem_q[rd_q];
    do_push = push_i && !full_o;
    do_pop  = pop_i && valid_o;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= entry_i;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("request pushed into full queue");

endmodule

>>> design/bdc_back.sv
// back end: emits the digits of one queued number, most significant first
module bdc_back import bdc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  bdc_entry_t         q_entry_i,
  output logic               q_pop_o,
  output logic               empty,
  input  logic               pop,
  output logic [CHAR_W-1:0]  digit_char_o,
  output logic [COUNT_W-1:0] digit_count_o,
  output logic               rejected_o,
  output logic               last_o
);

  bdc_entry_t         cur_q;
  logic               busy_q, busy_d;
  logic [COUNT_W-1:0] idx_q, idx_d;
  logic               adv, finish, take;
  logic [DIGIT_W-1:0] digit;

  // result fields from the current entry
  always_comb begin
    digit         = cur_q.digits[idx_q];
    empty         = !busy_q;
    rejected_o    = cur_q.rejected;
    digit_count_o = cur_q.count;
    digit_char_o  = cur_q.rejected ? '0 : ASCII_ZERO + CHAR_W'(digit);
    last_o        = cur_q.rejected || (idx_q == '0);
  end

  // sequencing: step through digits, load the next entry after the last one
  always_comb begin
    adv     = busy_q && pop;
    finish  = adv && last_o;
    take    = q_valid_i && (!busy_q || finish);
    q_pop_o = take;
    busy_d  = take ? 1'b1 : (finish ? 1'b0 : busy_q);
    if (take) begin
      idx_d = q_entry_i.rejected ? '0 : q_entry_i.count - COUNT_W'(1);
    end else if (adv) begin
      idx_d = idx_q - COUNT_W'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cur_q <= q_entry_i;
  end

  a_rej_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cur_q.rejected) |-> (idx_q == '0 && cur_q.count == '0))
    else $error("rejected request not a single result");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !cur_q.rejected) |-> (idx_q < cur_q.count))
    else $error("digit index beyond digit count");

endmodule

>>> design/binary_to_decimal_ascii.sv
// top level of the 64-bit binary to decimal ascii converter
//
//   channel   direction  handshake             payload
//   request   in         push / full           number_i
//   result    out        empty / pop           digit_char_o, digit_count_o, rejected_o, last_o
//   config    in         cfg_we_i              cfg_wdata_i (digit limit)
//
// the front end holds a number through accept, 16 conversion steps of 4 bits and classify.
// the back end sends one digit per cycle while pop is held, and a number of n digits gives n
// results; a rejected number gives one result.
// a queue of QueueDepth converted numbers sits between front and back end.
// reset clears the sequencers and the queue and sets the digit limit to 32.
// a stalled result output never blocks the front end until the queue fills.
module binary_to_decimal_ascii import bdc_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [NUM_W-1:0]   number_i,
  output logic               empty,
  input  logic               pop,
  output logic [CHAR_W-1:0]  digit_char_o,
  output logic [COUNT_W-1:0] digit_count_o,
  output logic               rejected_o,
  output logic               last_o,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i
);

  bdc_entry_t q_in, q_out;
  logic       q_push, q_full, q_pop, q_valid;

  // conversion and classification
  bdc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .number_i    (number_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_push_o    (q_push),
    .q_entry_o   (q_in),
    .q_full_i    (q_full)
  );

  // decoupling queue
  bdc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .valid_o (q_valid)
  );

  // digit output
  bdc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_out),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .digit_char_o  (digit_char_o),
    .digit_count_o (digit_count_o),
    .rejected_o    (rejected_o),
    .last_o        (last_o)
  );

endmodule
